@@ hdl/tclp_pkg.sv @@
package tclp_pkg;

  localparam int TEXT_CHARS_DEF      = 19;
  localparam int FRACTION_BITS_DEF   = 16;
  localparam int FRACTION_DIGITS_DEF = 6;

  localparam int INT_W  = 16;
  localparam int FACC_W = 20;
  localparam int FCNT_W = 3;
  localparam int ACT_W  = 3;
  localparam int IDX_W  = 5;

  localparam int                FULL_DIGITS = 6;
  localparam logic [FACC_W-1:0] FRAC_SCALE  = 20'd1000000;

  localparam logic [ACT_W-1:0] ACT_NONE  = 3'd0;
  localparam logic [ACT_W-1:0] ACT_START = 3'd1;
  localparam logic [ACT_W-1:0] ACT_STOP  = 3'd2;
  localparam logic [ACT_W-1:0] ACT_SET   = 3'd3;
  localparam logic [ACT_W-1:0] ACT_BASE  = 3'd4;
  localparam logic [ACT_W-1:0] ACT_TASK  = 3'd5;

  localparam logic [7:0] CMD_START = "s";
  localparam logic [7:0] CMD_STOP  = "p";
  localparam logic [7:0] CMD_BASE  = "h";
  localparam logic [7:0] CMD_TASK  = "t";

  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic [IDX_W-1:0] param_index;
    logic             beep;
  } tclp_dec_t;

  typedef struct packed {
    logic [7:0]        cmd;
    logic              has;
    logic              neg;
    logic [INT_W-1:0]  iacc;
    logic [FACC_W-1:0] facc;
    logic [FCNT_W-1:0] fcnt;
    tclp_dec_t         dec;
  } tclp_snap_t;

  function automatic logic [FACC_W-1:0] pow10(input logic [FCNT_W-1:0] k);
    logic [FACC_W-1:0] p;
    unique case (k)
      3'd0:    p = 20'd1;
      3'd1:    p = 20'd10;
      3'd2:    p = 20'd100;
      3'd3:    p = 20'd1000;
      3'd4:    p = 20'd10000;
      3'd5:    p = 20'd100000;
      default: p = 20'd1000000;
    endcase
    return p;
  endfunction

  function automatic tclp_dec_t decode_cmd(input logic [7:0] cmd, input logic has);
    tclp_dec_t        d;
    logic             hit;
    logic [IDX_W-1:0] idx;
    d   = '0;
    hit = 1'b1;
    idx = '0;
    unique case (cmd)
      "a":     idx = 5'd0;
      "c":     idx = 5'd1;
      "e":     idx = 5'd2;
      "d":     idx = 5'd3;
      "f":     idx = 5'd4;
      "g":     idx = 5'd5;
      "m":     idx = 5'd6;
      "o":     idx = 5'd7;
      "q":     idx = 5'd8;
      "s":     idx = 5'd9;
      "u":     idx = 5'd10;
      "w":     idx = 5'd11;
      "i":     idx = 5'd12;
      "k":     idx = 5'd13;
      "l":     idx = 5'd14;
      "j":     idx = 5'd15;
      "p":     idx = 5'd16;
      "r":     idx = 5'd17;
      "b":     idx = 5'd18;
      "n":     idx = 5'd19;
      "x":     idx = 5'd20;
      "y":     idx = 5'd21;
      "z":     idx = 5'd22;
      "v":     idx = 5'd23;
      default: hit = 1'b0;
    endcase
    if (!has) begin
      if (cmd == CMD_START) begin
        d.action = ACT_START;
      end else if (cmd == CMD_STOP) begin
        d.action = ACT_STOP;
      end
    end else if (hit) begin
      d.action      = ACT_SET;
      d.param_index = idx;
      d.beep        = 1'b1;
    end else if (cmd == CMD_BASE) begin
      d.action = ACT_BASE;
      d.beep   = 1'b1;
    end else if (cmd == CMD_TASK) begin
      d.action = ACT_TASK;
      d.beep   = 1'b1;
    end
    return d;
  endfunction

endpackage

@@ hdl/tclp_in_if.sv @@
interface tclp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       link_ready;

  modport source (output valid, output rx_byte, output link_ready, input ready);
  modport sink (input valid, input rx_byte, input link_ready, output ready);
endinterface

@@ hdl/tclp_out_if.sv @@
interface tclp_out_if;
  logic               valid;
  logic               ready;
  logic [7:0]         command_letter;
  logic signed [31:0] parsed_value;
  logic               has_value;
  logic [2:0]         action;
  logic [4:0]         param_index;
  logic signed [15:0] whole_value;
  logic               beep_request;

  modport source (
    output valid, output command_letter, output parsed_value, output has_value,
    output action, output param_index, output whole_value, output beep_request,
    input ready
  );
  modport sink (
    input valid, input command_letter, input parsed_value, input has_value,
    input action, input param_index, input whole_value, input beep_request,
    output ready
  );
endinterface

@@ hdl/tclp_parser.sv @@
module tclp_parser #(
  parameter int TEXT_CHARS      = tclp_pkg::TEXT_CHARS_DEF,
  parameter int FRACTION_DIGITS = tclp_pkg::FRACTION_DIGITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  tclp_in_if.sink              in_if,
  input  logic                 adv,
  output logic                 snap_valid,
  output tclp_pkg::tclp_snap_t snap
);

  localparam int CNT_W = $clog2(TEXT_CHARS + 1);

  localparam logic [1:0] PH_LEAD = 2'd0;
  localparam logic [1:0] PH_CMD  = 2'd1;
  localparam logic [1:0] PH_TEXT = 2'd2;

  localparam logic [2:0] NP_BLANK = 3'd0;
  localparam logic [2:0] NP_SIGN  = 3'd1;
  localparam logic [2:0] NP_INT   = 3'd2;
  localparam logic [2:0] NP_FRAC  = 3'd3;
  localparam logic [2:0] NP_STOP  = 3'd4;

  localparam logic [7:0] CH_LEAD  = "C";
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_PLUS  = "+";
  localparam logic [7:0] CH_MINUS = "-";
  localparam logic [7:0] CH_POINT = ".";
  localparam logic [7:0] CH_ZERO  = "0";
  localparam logic [7:0] CH_NINE  = "9";

  logic [1:0]                  phase_r, phase_nxt;
  logic [7:0]                  cmd_r, cmd_nxt;
  logic [CNT_W-1:0]            count_r, count_nxt;
  logic [2:0]                  nphase_r, nphase_nxt;
  logic                        neg_r, neg_nxt;
  logic [tclp_pkg::INT_W-1:0]  iacc_r, iacc_nxt;
  logic [tclp_pkg::FACC_W-1:0] facc_r, facc_nxt;
  logic [tclp_pkg::FCNT_W-1:0] fcnt_r, fcnt_nxt;
  logic                        snap_valid_r;
  tclp_pkg::tclp_snap_t        snap_r, snap_nxt;

  logic [7:0]                  b;
  logic                        accept;
  logic                        take;
  logic                        term;
  logic                        emit;
  logic                        blank;
  logic                        digit;
  logic [7:0]                  doff;
  logic [3:0]                  d;
  logic [19:0]                 int_prod;
  logic [tclp_pkg::INT_W-1:0]  int_sat;
  logic [tclp_pkg::FACC_W-1:0] frac_prod;

  assign in_if.ready = adv || !snap_valid_r;
  assign accept      = in_if.valid && in_if.ready;
  assign take        = accept && in_if.link_ready;
  assign b           = in_if.rx_byte;

  assign term  = (b == CH_CR) || (b == CH_LF);
  assign blank = (b == CH_SPACE) || (b == CH_TAB) || (b == CH_VT) || (b == CH_FF);
  assign digit = (b >= CH_ZERO) && (b <= CH_NINE);
  assign doff  = b - CH_ZERO;
  assign d     = doff[3:0];

  assign int_prod  = ({4'b0, iacc_r} << 3) + ({4'b0, iacc_r} << 1) + {16'b0, d};
  assign int_sat   = (int_prod > 20'd65535) ? 16'hFFFF : int_prod[15:0];
  assign frac_prod = (facc_r << 3) + (facc_r << 1) + {16'b0, d};

  assign emit = take && (phase_r == PH_TEXT) && term;

  always_comb begin
    phase_nxt  = phase_r;
    cmd_nxt    = cmd_r;
    count_nxt  = count_r;
    nphase_nxt = nphase_r;
    neg_nxt    = neg_r;
    iacc_nxt   = iacc_r;
    facc_nxt   = facc_r;
    fcnt_nxt   = fcnt_r;
    if (take) begin
      unique case (phase_r)
        PH_LEAD: begin
          if (b == CH_LEAD) begin
            phase_nxt = PH_CMD;
          end
        end
        PH_CMD: begin
          cmd_nxt    = b;
          count_nxt  = '0;
          nphase_nxt = NP_BLANK;
          neg_nxt    = 1'b0;
          iacc_nxt   = '0;
          facc_nxt   = '0;
          fcnt_nxt   = '0;
          phase_nxt  = PH_TEXT;
        end
        PH_TEXT: begin
          if (term) begin
            phase_nxt = PH_LEAD;
          end else if (count_r < CNT_W'(TEXT_CHARS)) begin
            count_nxt = count_r + 1'b1;
            unique case (nphase_r)
              NP_BLANK: begin
                priority if (blank) begin
                  nphase_nxt = NP_BLANK;
                end else if (b == CH_PLUS) begin
                  nphase_nxt = NP_SIGN;
                end else if (b == CH_MINUS) begin
                  neg_nxt    = 1'b1;
                  nphase_nxt = NP_SIGN;
                end else if (digit) begin
                  iacc_nxt   = int_sat;
                  nphase_nxt = NP_INT;
                end else if (b == CH_POINT) begin
                  nphase_nxt = NP_FRAC;
                end else begin
                  nphase_nxt = NP_STOP;
                end
              end
              NP_SIGN, NP_INT: begin
                priority if (digit) begin
                  iacc_nxt   = int_sat;
                  nphase_nxt = NP_INT;
                end else if (b == CH_POINT) begin
                  nphase_nxt = NP_FRAC;
                end else begin
                  nphase_nxt = NP_STOP;
                end
              end
              NP_FRAC: begin
                if (digit) begin
                  if (fcnt_r < tclp_pkg::FCNT_W'(FRACTION_DIGITS)) begin
                    facc_nxt = frac_prod;
                    fcnt_nxt = fcnt_r + 1'b1;
                  end
                end else begin
                  nphase_nxt = NP_STOP;
                end
              end
              default: nphase_nxt = NP_STOP;
            endcase
          end
        end
        default: phase_nxt = PH_LEAD;
      endcase
    end
  end

  always_comb begin
    snap_nxt      = '0;
    snap_nxt.cmd  = cmd_r;
    snap_nxt.has  = (count_r != '0);
    snap_nxt.neg  = neg_r;
    snap_nxt.iacc = iacc_r;
    snap_nxt.facc = facc_r;
    snap_nxt.fcnt = fcnt_r;
    snap_nxt.dec  = tclp_pkg::decode_cmd(cmd_r, count_r != '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_LEAD;
      cmd_r        <= '0;
      count_r      <= '0;
      nphase_r     <= NP_BLANK;
      neg_r        <= 1'b0;
      iacc_r       <= '0;
      facc_r       <= '0;
      fcnt_r       <= '0;
      snap_valid_r <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      cmd_r    <= cmd_nxt;
      count_r  <= count_nxt;
      nphase_r <= nphase_nxt;
      neg_r    <= neg_nxt;
      iacc_r   <= iacc_nxt;
      facc_r   <= facc_nxt;
      fcnt_r   <= fcnt_nxt;
      if (in_if.ready) begin
        snap_valid_r <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      snap_r <= snap_nxt;
    end
  end

  assign snap_valid = snap_valid_r;
  assign snap       = snap_r;

endmodule

@@ hdl/tclp_divider.sv @@
module tclp_divider #(
  parameter int FRACTION_BITS = tclp_pkg::FRACTION_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  logic                 snap_valid,
  input  tclp_pkg::tclp_snap_t snap,
  output logic                 q_valid,
  output tclp_pkg::tclp_snap_t q_snap,
  output logic [FRACTION_BITS:0] quot
);

  localparam int F_W   = tclp_pkg::FACC_W;
  localparam int S_W   = 2 * F_W;
  localparam int Q_W   = FRACTION_BITS + 1;
  localparam int SHIFT = F_W;
  localparam int P_W   = F_W + Q_W;

  localparam longint unsigned RECIP =
    (64'd1 << (FRACTION_BITS + SHIFT)) / 64'(tclp_pkg::FRAC_SCALE);
  localparam logic [Q_W-1:0] RECIP_K = Q_W'(RECIP);
  localparam logic [P_W-1:0] DIV1    = P_W'(tclp_pkg::FRAC_SCALE);
  localparam logic [P_W-1:0] DIV2    = DIV1 << 1;
  localparam logic [P_W-1:0] HALF    = DIV1 >> 1;

  logic [F_W-1:0]       scale;
  logic [S_W-1:0]       scaled;
  logic [P_W-1:0]       est_prod;
  logic [P_W-1:0]       num;
  logic [P_W-1:0]       back_prod;
  logic [P_W-1:0]       rem;
  logic [Q_W-1:0]       fix;

  logic                 v1_r, v2_r, v3_r, v4_r;
  tclp_pkg::tclp_snap_t snap1_r, snap2_r, snap3_r, snap4_r;
  logic [F_W-1:0]       f1_r;
  logic [Q_W-1:0]       qe2_r, qe3_r, quot_r;
  logic [P_W-1:0]       n2_r, n3_r, bp3_r;

  // The fraction digits are scaled to millionths, then divided by a reciprocal
  // multiplication whose estimate is at most two short and is corrected at the end.
  assign scale  = tclp_pkg::pow10(tclp_pkg::FCNT_W'(tclp_pkg::FULL_DIGITS) - snap.fcnt);
  assign scaled = S_W'(snap.facc) * S_W'(scale);

  assign est_prod  = P_W'(f1_r) * P_W'(RECIP_K);
  assign num       = (P_W'(f1_r) << FRACTION_BITS) + HALF;
  assign back_prod = P_W'(qe2_r) * DIV1;
  assign rem       = n3_r - bp3_r;
  assign fix       = (rem >= DIV2) ? Q_W'(2) : ((rem >= DIV1) ? Q_W'(1) : '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (adv) begin
      v1_r <= snap_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      snap1_r <= snap;
      f1_r    <= scaled[F_W-1:0];
      snap2_r <= snap1_r;
      qe2_r   <= est_prod[P_W-1:SHIFT];
      n2_r    <= num;
      snap3_r <= snap2_r;
      qe3_r   <= qe2_r;
      n3_r    <= n2_r;
      bp3_r   <= back_prod;
      snap4_r <= snap3_r;
      quot_r  <= qe3_r + fix;
    end
  end

  assign q_valid = v4_r;
  assign q_snap  = snap4_r;
  assign quot    = quot_r;

endmodule

@@ hdl/tclp_finish.sv @@
module tclp_finish #(
  parameter int FRACTION_BITS = tclp_pkg::FRACTION_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_valid,
  input  tclp_pkg::tclp_snap_t   q_snap,
  input  logic [FRACTION_BITS:0] quot,
  output logic                   adv,
  tclp_out_if.source             out_if
);

  localparam int MAG_W = tclp_pkg::INT_W + FRACTION_BITS + 1;
  localparam int CMP_W = (MAG_W > 32) ? MAG_W : 32;
  localparam int M_W   = 32 - FRACTION_BITS;
  localparam int CAP_W = (M_W > 16) ? M_W : 16;

  logic [MAG_W-1:0]     mag;
  logic [CMP_W-1:0]     mag_ext;
  logic [CMP_W-1:0]     lim;
  logic [31:0]          abs_nxt;

  logic                 a_vld_r;
  tclp_pkg::tclp_snap_t a_snap_r;
  logic [31:0]          abs_r;

  logic [31:0]          val_nxt;
  logic [M_W-1:0]       m;
  logic [CAP_W-1:0]     m_ext;
  logic [CAP_W-1:0]     cap;
  logic [15:0]          wm;
  logic [15:0]          whole_nxt;

  logic                 out_valid_r;
  logic [7:0]           cmd_r;
  logic [31:0]          val_r;
  logic                 has_r;
  tclp_pkg::tclp_dec_t  dec_r;
  logic [15:0]          whole_r;

  assign adv = !out_valid_r || out_if.ready;

  assign mag     = (MAG_W'(q_snap.iacc) << FRACTION_BITS) + MAG_W'(quot);
  assign mag_ext = CMP_W'(mag);
  assign lim     = q_snap.neg ? CMP_W'(32'h8000_0000) : CMP_W'(32'h7FFF_FFFF);
  assign abs_nxt = (mag_ext > lim) ? lim[31:0] : mag_ext[31:0];

  assign val_nxt   = a_snap_r.neg ? (32'd0 - abs_r) : abs_r;
  assign m         = abs_r[31:FRACTION_BITS];
  assign m_ext     = CAP_W'(m);
  assign cap       = a_snap_r.neg ? CAP_W'(32'd32768) : CAP_W'(32'd32767);
  assign wm        = (m_ext > cap) ? cap[15:0] : m_ext[15:0];
  assign whole_nxt = a_snap_r.neg ? (16'd0 - wm) : wm;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      a_vld_r     <= q_valid;
      out_valid_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_snap_r <= q_snap;
      abs_r    <= abs_nxt;
      cmd_r    <= a_snap_r.cmd;
      val_r    <= val_nxt;
      has_r    <= a_snap_r.has;
      dec_r    <= a_snap_r.dec;
      whole_r  <= whole_nxt;
    end
  end

  assign out_if.valid          = out_valid_r;
  assign out_if.command_letter = cmd_r;
  assign out_if.parsed_value   = val_r;
  assign out_if.has_value      = has_r;
  assign out_if.action         = dec_r.action;
  assign out_if.param_index    = dec_r.param_index;
  assign out_if.whole_value    = whole_r;
  assign out_if.beep_request   = dec_r.beep;

endmodule

@@ hdl/tuning_command_line_parser_top.sv @@
// Command line parser for tuning commands: one received byte is taken in every clock cycle
// while the input is not stalled, and the number text is converted as it arrives. A CR or LF
// beat closes the line: the line is captured in the snapshot register at the accepting edge,
// then passes through the fraction conversion registers (scaling to millionths, a reciprocal
// multiplication and a final correction) and the output registers before its result beat is
// presented. Results are fully pipelined, so lines may follow each other without gaps. A refused
// output freezes the fraction conversion and output stages, and the input stalls only when a
// finished line is waiting in the snapshot register while the output is refused.
module tuning_command_line_parser_top #(
  parameter int TEXT_CHARS      = tclp_pkg::TEXT_CHARS_DEF,
  parameter int FRACTION_BITS   = tclp_pkg::FRACTION_BITS_DEF,
  parameter int FRACTION_DIGITS = tclp_pkg::FRACTION_DIGITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  tclp_in_if.sink    in_if,
  tclp_out_if.source out_if
);

  logic                   adv;
  logic                   snap_valid;
  tclp_pkg::tclp_snap_t   snap;
  logic                   q_valid;
  tclp_pkg::tclp_snap_t   q_snap;
  logic [FRACTION_BITS:0] quot;

  tclp_parser #(
    .TEXT_CHARS      (TEXT_CHARS),
    .FRACTION_DIGITS (FRACTION_DIGITS)
  ) u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_if      (in_if),
    .adv        (adv),
    .snap_valid (snap_valid),
    .snap       (snap)
  );

  tclp_divider #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_divider (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .snap_valid (snap_valid),
    .snap       (snap),
    .q_valid    (q_valid),
    .q_snap     (q_snap),
    .quot       (quot)
  );

  tclp_finish #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_finish (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_snap  (q_snap),
    .quot    (quot),
    .adv     (adv),
    .out_if  (out_if)
  );

endmodule
